// ----- sv/assert_macros.svh -----
// Assertion macros shared by the range-sum tree RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/strs_pkg.sv -----
// Shared types and constants for the segment-tree range-sum unit.
// No dependencies; used by strs_ctrl, strs_datapath and the top level.
package strs_pkg;

  localparam int LEAF_COUNT_DEF = 1024;
  localparam int IDX_W          = 10;
  localparam int VAL_W          = 32;
  localparam int RANGE_W        = 11;
  localparam int SUM_W          = 64;

  typedef struct packed {
    logic clr_step;
    logic ld_write;
    logic ld_query;
    logic w_up;
    logic q_a;
    logic q_b;
    logic res_load;
  } strs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_ok;
    logic a_lt_b;
    logic at_root;
  } strs_stat_t;

endpackage

// ----- sv/strs_datapath.sv -----
// Datapath: node-sum memory, tree walk registers, accumulator, result register.
// Depends on strs_pkg and assert_macros.svh; driven by strs_ctrl.
`include "assert_macros.svh"

module strs_datapath import strs_pkg::*; #(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  strs_cmd_t                 cmd,
  output strs_stat_t                stat,
  input  logic [IDX_W-1:0]          leaf_index,
  input  logic signed [VAL_W-1:0]   leaf_value,
  input  logic [RANGE_W-1:0]        range_left,
  input  logic [RANGE_W-1:0]        range_right,
  output logic signed [SUM_W-1:0]   range_total
);

  localparam int LW   = $clog2(LEAF_COUNT);
  localparam int SPAN = 1 << LW;
  localparam int NW   = LW + 1;
  localparam int AW   = LW + 2;
  localparam int DEPTH = 2 * SPAN;

  logic [SUM_W-1:0] node_mem [DEPTH];

  logic [AW-1:0]    a;
  logic [AW-1:0]    b;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] rdata;
  logic             rd_q;
  logic [NW-1:0]    clr_addr;

  logic [31:0]      idx32;
  logic [31:0]      lo32;
  logic [31:0]      hi32;
  logic [31:0]      lo_c;
  logic [31:0]      hi_c;
  logic [NW-1:0]    leaf;
  logic [NW-1:0]    parent;
  logic [SUM_W-1:0] val64;
  logic [SUM_W-1:0] sum;

  logic             wr_en;
  logic [NW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;
  logic             rd_en;
  logic [NW-1:0]    rd_addr;

  always_comb begin
    idx32  = 32'(leaf_index);
    lo32   = 32'(range_left);
    hi32   = 32'(range_right);
    lo_c   = (lo32 > 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT) : lo32;
    hi_c   = (hi32 > 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT) : hi32;
    leaf   = {1'b1, idx32[LW-1:0]};
    parent = {1'b0, a[NW-1:1]};
    val64  = {{(SUM_W-VAL_W){leaf_value[VAL_W-1]}}, leaf_value};
    sum    = acc + rdata;
  end

  // memory port selection
  always_comb begin
    wr_en   = cmd.clr_step | cmd.ld_write | cmd.w_up;
    wr_addr = parent;
    wr_data = sum;
    if (cmd.clr_step) begin
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.ld_write) begin
      wr_addr = leaf;
      wr_data = val64;
    end

    rd_en   = cmd.ld_write | cmd.w_up | (cmd.q_a & a[0]) | (cmd.q_b & b[0]);
    rd_addr = parent ^ NW'(1);
    if (cmd.ld_write) begin
      rd_addr = leaf ^ NW'(1);
    end else if (cmd.q_a) begin
      rd_addr = a[NW-1:0];
    end else if (cmd.q_b) begin
      rd_addr = {b[NW-1:1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q     <= 1'b0;
      clr_addr <= '0;
    end else begin
      rd_q <= (cmd.q_a & a[0]) | (cmd.q_b & b[0]);
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      a   <= AW'(lo_c) + AW'(SPAN);
      b   <= AW'(hi_c) + AW'(SPAN);
      acc <= '0;
    end else if (cmd.ld_write) begin
      a   <= AW'(leaf);
      acc <= val64;
    end else if (cmd.w_up) begin
      a   <= AW'(parent);
      acc <= sum;
    end else begin
      if (rd_q) begin
        acc <= sum;
      end
      if (cmd.q_a && a[0]) begin
        a <= a + AW'(1);
      end else if (cmd.q_b) begin
        a <= a >> 1;
        b <= b >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      range_total <= acc;
    end
  end

  always_comb begin
    stat.clr_last = (clr_addr == '1);
    stat.idx_ok   = (idx32 < 32'(LEAF_COUNT));
    stat.a_lt_b   = (a < b);
    stat.at_root  = (a[NW-1:1] == LW'(1));
  end

  `ASSERT_IMPLY(a_wup_below_root, clk, rst, cmd.w_up, a[NW-1:1] != '0)
  `ASSERT_IMPLY(a_qa_in_range, clk, rst, cmd.q_a, a < b)
  `ASSERT_IMPLY(a_write_valid_leaf, clk, rst, cmd.ld_write, idx32 < 32'(LEAF_COUNT))

endmodule

// ----- sv/strs_ctrl.sv -----
// Controller: sequences clearing, leaf writes, range walks and result hand-off.
// Depends on strs_pkg and assert_macros.svh; drives strs_datapath.
`include "assert_macros.svh"

module strs_ctrl import strs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       mode,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  strs_stat_t stat,
  output strs_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WUP   = 3'd2;
  localparam logic [2:0] S_QA    = 3'd3;
  localparam logic [2:0] S_QB    = 3'd4;
  localparam logic [2:0] S_QDONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (mode) begin
            cmd.ld_query = 1'b1;
            state_next   = S_QA;
          end else if (stat.idx_ok) begin
            cmd.ld_write = 1'b1;
            state_next   = S_WUP;
          end
        end
      end
      S_WUP: begin
        cmd.w_up = 1'b1;
        if (stat.at_root) begin
          state_next = S_IDLE;
        end
      end
      S_QA: begin
        if (stat.a_lt_b) begin
          cmd.q_a    = 1'b1;
          state_next = S_QB;
        end else begin
          state_next = S_QDONE;
        end
      end
      S_QB: begin
        cmd.q_b    = 1'b1;
        state_next = S_QA;
      end
      S_QDONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(c_query_enters_walk, clk, rst, s_tvalid && s_tready && mode, state == S_QA)
  `ASSERT_IMPLY(c_clear_blocks_input, clk, rst, state == S_CLEAR, !s_tready)
  `ASSERT_IMPLY(c_no_result_overwrite, clk, rst, cmd.res_load && m_tvalid, m_tready)

endmodule

// ----- sv/segment_tree_range_sum_unit.sv -----
// Segment-tree range-sum unit, top level: stream ports, controller and datapath.
// Depends on strs_pkg, strs_ctrl and strs_datapath.
//
// Holds a sum tree over P leaves (P = LEAF_COUNT rounded up to a power of two)
// in a single-port-read node memory of 2*P 64-bit entries. After reset the
// memory is swept to zero, one entry per cycle, with s_tready low. A leaf write
// stores the leaf, then climbs the tree one level at a time, each step adding
// the running sum to the sibling read in the previous cycle and writing the
// parent. A write to a leaf at or beyond LEAF_COUNT is dropped. A query walks
// both range ends up the tree, taking the left end and then the right end in
// turn at each level, since the node memory has a single read port; the result
// load waits while an earlier result is still not accepted. The result sits in
// an output register, so a new request is taken while it waits.
module segment_tree_range_sum_unit import strs_pkg::*; #(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // leaf_index[9:0], leaf_value[41:10],
                                // range_left[52:42], range_right[63:53]
  input  logic        s_tuser,  // mode[0]: 0 write, 1 query
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // range_total[63:0]
);

  strs_cmd_t                 cmd;
  strs_stat_t                stat;
  logic signed [SUM_W-1:0]   range_total;

  strs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  strs_datapath #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .leaf_index  (s_tdata[9:0]),
    .leaf_value  (s_tdata[41:10]),
    .range_left  (s_tdata[52:42]),
    .range_right (s_tdata[63:53]),
    .range_total (range_total)
  );

  assign m_tdata = range_total;

endmodule
